### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the header tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables checking.
`define HHT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Implication checked on the same edge.
`define HHT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  `HHT_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

// Implication checked on the following edge.
`define HHT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  `HHT_ASSERT(name, clk, rst_n, (ante) |=> (cons), msg)

`endif

### design/hht_pkg.sv
// ----------------------------------------------------------------------------
// Header tokenizer package
// Types, codes and character constants shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package hht_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 10;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [OffsetW-1:0] MaxOffsetReset = OffsetW'(255);

  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;

  typedef enum logic [3:0] {
    StStart  = 4'd0,
    StKey    = 4'd1,
    StColon  = 4'd2,
    StSpace  = 4'd3,
    StValue  = 4'd4,
    StCr     = 4'd5,
    StLf     = 4'd6,
    StEndCr  = 4'd7
  } parse_state_e;

  typedef enum logic [ClassW-1:0] {
    ClsSkip    = 3'd0,
    ClsKey     = 3'd1,
    ClsSep     = 3'd2,
    ClsValue   = 3'd3,
    ClsLineCr  = 3'd4,
    ClsLineLf  = 3'd5,
    ClsFinalCr = 3'd6,
    ClsEnd     = 3'd7
  } byte_class_e;

  typedef enum logic [StatusW-1:0] {
    StatBusy = 2'd0,
    StatDone = 2'd1,
    StatErr  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    byte_class_e      cls;
    status_e          status;
  } result_t;

endpackage

### design/hht_in_reg.sv
// ----------------------------------------------------------------------------
// Header tokenizer input register
// Captures one input transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module hht_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hht_pkg::in_item_t item_i,
  input  logic              down_ready_i,
  output logic              valid_o,
  output logic              fire_o,
  output hht_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  logic              load;
  hht_pkg::in_item_t item_q;

  assign fire_o     = valid_q && down_ready_i;
  assign in_stall_o = valid_q && !down_ready_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !fire_o);
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

### design/hht_parser.sv
// ----------------------------------------------------------------------------
// Header tokenizer parser
// Parser state, value offset counter and sticky status, with the byte
// classification logic that produces one result per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hht_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  hht_pkg::in_item_t            item_i,
  input  logic [hht_pkg::OffsetW-1:0]  max_offset_i,
  output hht_pkg::result_t             result_o
);

  hht_pkg::parse_state_e       state_q, state_d;
  logic [hht_pkg::OffsetW-1:0] offset_q, offset_d;
  hht_pkg::status_e            status_q, status_d;
  hht_pkg::byte_class_e        cls;
  logic                        err;
  logic [hht_pkg::ByteW-1:0]   b;

  assign b = item_i.data;

  always_comb begin
    state_d  = state_q;
    offset_d = offset_q;
    status_d = status_q;
    cls      = hht_pkg::ClsSkip;
    err      = 1'b0;
    if (item_i.restart) begin
      state_d  = hht_pkg::StStart;
      offset_d = '0;
      status_d = hht_pkg::StatBusy;
    end else if (status_q == hht_pkg::StatBusy) begin
      case (state_q)
        hht_pkg::StKey: begin
          if (b == hht_pkg::ChColon) begin
            cls     = hht_pkg::ClsSep;
            state_d = hht_pkg::StColon;
          end else if (b == hht_pkg::ChCr || b == hht_pkg::ChLf) begin
            err = 1'b1;
          end else begin
            cls = hht_pkg::ClsKey;
          end
        end
        hht_pkg::StColon: begin
          if (b == hht_pkg::ChSpace) begin
            cls     = hht_pkg::ClsSep;
            state_d = hht_pkg::StSpace;
          end else begin
            err = 1'b1;
          end
        end
        hht_pkg::StSpace: begin
          cls      = hht_pkg::ClsValue;
          offset_d = '0;
          state_d  = hht_pkg::StValue;
        end
        hht_pkg::StValue: begin
          if (b == hht_pkg::ChCr) begin
            cls     = hht_pkg::ClsLineCr;
            state_d = hht_pkg::StCr;
          end else if (offset_q >= max_offset_i) begin
            err = 1'b1;
          end else begin
            cls      = hht_pkg::ClsValue;
            offset_d = offset_q + hht_pkg::OffsetW'(1);
          end
        end
        hht_pkg::StCr: begin
          if (b == hht_pkg::ChLf) begin
            cls     = hht_pkg::ClsLineLf;
            state_d = hht_pkg::StLf;
          end else begin
            err = 1'b1;
          end
        end
        hht_pkg::StLf: begin
          if (b == hht_pkg::ChCr) begin
            cls     = hht_pkg::ClsFinalCr;
            state_d = hht_pkg::StEndCr;
          end else begin
            cls     = hht_pkg::ClsKey;
            state_d = hht_pkg::StKey;
          end
        end
        hht_pkg::StEndCr: begin
          if (b == hht_pkg::ChLf) begin
            cls      = hht_pkg::ClsEnd;
            status_d = hht_pkg::StatDone;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          if (b != hht_pkg::ChCr && b != hht_pkg::ChLf) begin
            cls     = hht_pkg::ClsKey;
            state_d = hht_pkg::StKey;
          end
        end
      endcase
      if (err) begin
        cls      = hht_pkg::ClsSkip;
        status_d = hht_pkg::StatErr;
      end
    end
  end

  assign result_o.data   = b;
  assign result_o.cls    = cls;
  assign result_o.status = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hht_pkg::StStart;
      offset_q <= '0;
      status_q <= hht_pkg::StatBusy;
    end else if (fire_i) begin
      state_q  <= state_d;
      offset_q <= offset_d;
      status_q <= status_d;
    end
  end

  `HHT_ASSERT_NEXT(a_sticky_holds, clk_i, rst_ni,
    fire_i && !item_i.restart && status_q != hht_pkg::StatBusy,
    $stable(state_q) && $stable(offset_q) && $stable(status_q),
    "Parser state changed while status was sticky")
  `HHT_ASSERT_IMPL(a_end_means_done, clk_i, rst_ni,
    result_o.cls == hht_pkg::ClsEnd, result_o.status == hht_pkg::StatDone,
    "End class given without done status")
  `HHT_ASSERT_IMPL(a_error_is_skip, clk_i, rst_ni,
    status_q == hht_pkg::StatBusy && result_o.status == hht_pkg::StatErr,
    result_o.cls == hht_pkg::ClsSkip,
    "Offending byte not classified as skipped")

endmodule

### design/hht_out_reg.sv
// ----------------------------------------------------------------------------
// Header tokenizer result register
// Holds one result transfer until the downstream side takes it.
// ----------------------------------------------------------------------------
module hht_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hht_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hht_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  hht_pkg::result_t result_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign valid_d     = load_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

### design/http_header_tokenizer.sv
// ----------------------------------------------------------------------------
// HTTP header tokenizer
// Byte-serial classifier for the header block of an HTTP request.
// ----------------------------------------------------------------------------
// Each input transfer carries one header byte (or a restart) and yields exactly
// one result transfer with the byte, its class and the parser status. The
// block takes one byte per clock cycle when the output is not stalled; a byte
// passes an input register and the parser logic and is loaded into the result
// register once the result register can take it, and leaves from there. The
// parser state update is the loop that sets this rate. Error and done status
// stay until a restart.
// The value length limit register may be written only while the block is idle.
`include "assert_macros.svh"

module http_header_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hht_pkg::OffsetW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hht_pkg::ByteW-1:0]   in_byte_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hht_pkg::ByteW-1:0]   byte_out_o,
  output logic [hht_pkg::ClassW-1:0]  byte_class_o,
  output logic [hht_pkg::StatusW-1:0] status_o
);

  logic [hht_pkg::OffsetW-1:0] max_offset_q;
  hht_pkg::in_item_t           in_item, s1_item;
  hht_pkg::result_t            parse_res, out_res;
  logic                        s1_valid, fire, out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_offset_q <= hht_pkg::MaxOffsetReset;
    end else if (cfg_we_i) begin
      max_offset_q <= cfg_wdata_i;
    end
  end

  assign in_item.data    = in_byte_i;
  assign in_item.restart = restart_i;

  hht_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .down_ready_i (out_ready),
    .valid_o      (s1_valid),
    .fire_o       (fire),
    .item_o       (s1_item)
  );

  hht_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (s1_item),
    .max_offset_i (max_offset_q),
    .result_o     (parse_res)
  );

  hht_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (parse_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign byte_out_o   = out_res.data;
  assign byte_class_o = out_res.cls;
  assign status_o     = out_res.status;

  `HHT_ASSERT_IMPL(a_stall_needs_item, clk_i, rst_ni,
    in_stall_o, s1_valid && out_valid_o && out_stall_i,
    "Input stalled without a held item and a stalled result")

endmodule
